// ===== hw/rtl/xbt_pkg.sv =====
// Shared types, character codes, lexer state codes and event codes for the XML tokenizer.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package xbt_pkg;

    // Defaults for the top level parameters
    localparam int ENTITY_NAME_MAX_DEF = 15;
    localparam int DTD_NEST_MAX_DEF    = 255;

    // Result events
    localparam logic [3:0] EV_TEXT      = 4'd0;
    localparam logic [3:0] EV_TAG_NAME  = 4'd1;
    localparam logic [3:0] EV_ATTR_NAME = 4'd2;
    localparam logic [3:0] EV_ATTR_VAL  = 4'd3;
    localparam logic [3:0] EV_SEP       = 4'd4;
    localparam logic [3:0] EV_TEXT_END  = 4'd5;
    localparam logic [3:0] EV_START_END = 4'd6;
    localparam logic [3:0] EV_SINGLE    = 4'd7;
    localparam logic [3:0] EV_ETAG_END  = 4'd8;
    localparam logic [3:0] EV_EOF       = 4'd9;

    // Lexer states
    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_TEXT      = 5'd1;
    localparam logic [4:0] S_TEXT_ENT  = 5'd2;
    localparam logic [4:0] S_LT        = 5'd3;
    localparam logic [4:0] S_ETAG_NAME = 5'd4;
    localparam logic [4:0] S_ETAG_SKIP = 5'd5;
    localparam logic [4:0] S_PI        = 5'd6;
    localparam logic [4:0] S_BANG      = 5'd7;
    localparam logic [4:0] S_BANG_DASH = 5'd8;
    localparam logic [4:0] S_DTD       = 5'd9;
    localparam logic [4:0] S_COM       = 5'd10;
    localparam logic [4:0] S_COM_D1    = 5'd11;
    localparam logic [4:0] S_COM_D2    = 5'd12;
    localparam logic [4:0] S_TAG_NAME  = 5'd13;
    localparam logic [4:0] S_ATTR_WS   = 5'd14;
    localparam logic [4:0] S_ATTR_NAME = 5'd15;
    localparam logic [4:0] S_EQ        = 5'd16;
    localparam logic [4:0] S_VALUE     = 5'd17;
    localparam logic [4:0] S_VALUE_ENT = 5'd18;
    localparam logic [4:0] S_SLASH     = 5'd19;
    localparam logic [4:0] S_DONE      = 5'd20;

    // Configuration register indexes
    localparam logic [0:0] REG_KEEP_WS     = 1'd0;
    localparam logic [0:0] REG_SPLIT_LIMIT = 1'd1;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QM    = 8'h3F;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_X     = 8'h78;

    // Named entities: names padded to four bytes, their lengths and decoded characters
    localparam int NUM_NAMED = 5;
    localparam logic [3:0][7:0] ENT_NAMES [NUM_NAMED] = '{
        {8'h00, 8'h00, 8'h74, 8'h6C},   // lt
        {8'h00, 8'h00, 8'h74, 8'h67},   // gt
        {8'h00, 8'h70, 8'h6D, 8'h61},   // amp
        {8'h73, 8'h6F, 8'h70, 8'h61},   // apos
        {8'h74, 8'h6F, 8'h75, 8'h71}    // quot
    };
    localparam int ENT_LENS [NUM_NAMED] = '{2, 2, 3, 4, 4};
    localparam logic [7:0] ENT_CHARS [NUM_NAMED] = '{CH_LT, CH_GT, CH_AMP, CH_SQ, CH_DQ};

    // One result word and the list of results caused by one input word
    typedef struct packed {
        logic [3:0] ev;
        logic [7:0] ch;
    } res_t;

    typedef struct packed {
        logic [1:0]       n;
        res_t [2:0]       r;
    } res_list_t;

    // Requests from the lexer to the entity tracker
    typedef struct packed {
        logic       clr;
        logic       push;
        logic [7:0] data;
    } ent_ctl_t;

    function automatic logic is_ws(logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_FF
            || c == CH_VT;
    endfunction

    function automatic res_list_t add_res(res_list_t l, logic [3:0] ev, logic [7:0] ch);
        res_list_t o;
        o = l;
        if (l.n < 2'd3)
        begin
            o.r[l.n] = '{ev: ev, ch: ch};
            o.n      = l.n + 2'd1;
        end
        return o;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/xml_byte_tokenizer_unit.sv =====
// Top level of the streaming XML tokenizer: lexer, entity tracker and result buffer.
// Depends on xbt_pkg, xbt_lexer, xbt_entity and xbt_result_buf.
//
//  channel  | direction | word contents
//  ---------+-----------+------------------------------------------------
//  s_axis   | in        | tdata[7:0] in_byte, tlast end_of_input
//  m_axis   | out       | tdata[7:0] out_char, tuser[3:0] event_res, tlast last
//  cfg      | in        | cfg_index register, cfg_data value
//
// A byte is decoded in the cycle it is accepted and its results are registered.
// Each result takes one output word, so a byte gives zero to three words:
// the three-entry buffer, drained one word a cycle if not stalled, sets the rate.
// The next byte is taken in the cycle the last result leaves; a byte without results
// leaves the buffer empty. Output stalls back up into s_axis_tready at once.
// Reset clears the lexer to idle and the configuration to zero; no clearing pass.
`default_nettype none
module xml_byte_tokenizer_unit
    import xbt_pkg::*;
#(
    parameter int ENTITY_NAME_MAX = ENTITY_NAME_MAX_DEF,
    parameter int DTD_NEST_MAX    = DTD_NEST_MAX_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,   // end_of_input
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_char
    output logic [3:0]       m_axis_tuser,   // [3:0] event_res
    output logic             m_axis_tlast,   // last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic      accept;
    logic      space;
    res_list_t results;
    res_t      head;

    assign s_axis_tready = space;
    assign accept        = s_axis_tvalid && space;
    assign cfg_ready     = 1'b1;

    xbt_lexer #(
        .ENTITY_NAME_MAX(ENTITY_NAME_MAX),
        .DTD_NEST_MAX   (DTD_NEST_MAX)
    ) u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (s_axis_tdata),
        .end_of_input(s_axis_tlast),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .results     (results)
    );

    xbt_result_buf u_result_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .load_list(results),
        .space    (space),
        .valid    (m_axis_tvalid),
        .take     (m_axis_tready),
        .head     (head),
        .last     (m_axis_tlast)
    );

    assign m_axis_tdata = head.ch;
    assign m_axis_tuser = head.ev;

    // Only defined event codes leave the block
    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser <= EV_EOF)
        else $error("undefined event code on output");

    // An end mark always yields at least one result
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> m_axis_tvalid)
        else $error("end of input gave no result");

    // With nothing to deliver the block takes input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output is empty");

endmodule
`default_nettype wire

// ===== hw/rtl/xbt_entity.sv =====
// Entity reference tracker: follows the entity name byte by byte and keeps its decode ready.
// Depends on xbt_pkg.
`default_nettype none
module xbt_entity
    import xbt_pkg::*;
#(
    parameter int ENTITY_NAME_MAX = ENTITY_NAME_MAX_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ent_ctl_t   ctl,
    output logic [7:0]      value
);

    localparam int LEN_W = $clog2(ENTITY_NAME_MAX + 1);

    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 hash_reg, hash_next;
    logic                 x_reg, x_next;
    logic [7:0]           hex_reg, hex_next;
    logic                 hex_stop_reg, hex_stop_next;
    logic [7:0]           dec_reg, dec_next;
    logic                 dec_stop_reg, dec_stop_next;
    logic [NUM_NAMED-1:0] match_reg, match_next;

    // Fold one name byte into the running decodes
    always_comb
    begin
        logic [7:0] b;
        logic [3:0] hd;
        logic       hv;
        logic [7:0] dsum;
        b             = ctl.data;
        len_next      = len_reg;
        hash_next     = hash_reg;
        x_next        = x_reg;
        hex_next      = hex_reg;
        hex_stop_next = hex_stop_reg;
        dec_next      = dec_reg;
        dec_stop_next = dec_stop_reg;
        match_next    = match_reg;
        hv            = 1'b1;
        hd            = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)      hd = 4'(b - 8'h30);
        else if (b >= 8'h41 && b <= 8'h46) hd = 4'(b - 8'h37);
        else if (b >= 8'h61 && b <= 8'h66) hd = 4'(b - 8'h57);
        else                               hv = 1'b0;
        dsum = 8'(b - 8'h30);
        if (ctl.clr)
        begin
            len_next      = '0;
            hex_next      = '0;
            hex_stop_next = 1'b0;
            dec_next      = '0;
            dec_stop_next = 1'b0;
            match_next    = '1;
        end
        else if (ctl.push && len_reg < LEN_W'(ENTITY_NAME_MAX))
        begin
            len_next = len_reg + 1'b1;
            for (int k = 0; k < NUM_NAMED; k++)
            begin
                if (!(len_reg < LEN_W'(ENT_LENS[k]) && b == ENT_NAMES[k][len_reg[1:0]]))
                    match_next[k] = 1'b0;
            end
            if (len_reg == '0) hash_next = (b == CH_HASH);
            if (len_reg == LEN_W'(1)) x_next = (b == CH_X);
            // Hex digits from the third byte on
            if (len_reg >= LEN_W'(2) && !hex_stop_reg)
            begin
                hex_next = {hex_reg[3:0], 4'd0};
                if (hv) hex_next = {hex_reg[3:0], hd};
                else    hex_stop_next = 1'b1;
            end
            // Decimal digits from the second byte on
            if (len_reg >= LEN_W'(1) && !dec_stop_reg)
            begin
                dec_next = 8'({dec_reg, 3'd0} + {dec_reg, 1'b0});
                if (b >= 8'h30 && b <= 8'h39) dec_next = 8'(dec_next + dsum);
                else                          dec_stop_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg     <= hash_next;
        x_reg        <= x_next;
        hex_reg      <= hex_next;
        hex_stop_reg <= hex_stop_next;
        dec_reg      <= dec_next;
        dec_stop_reg <= dec_stop_next;
        match_reg    <= match_next;
    end

    // Decoded character: named entities first, then hex, then decimal references
    always_comb
    begin
        value = 8'd0;
        if (len_reg >= LEN_W'(2) && hash_reg && x_reg) value = hex_reg;
        else if (len_reg >= LEN_W'(1) && hash_reg)     value = dec_reg;
        for (int k = 0; k < NUM_NAMED; k++)
        begin
            if (match_reg[k] && len_reg == LEN_W'(ENT_LENS[k])) value = ENT_CHARS[k];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/xbt_lexer.sv =====
// Lexer state machine and configuration registers: turns one byte into up to three results.
// Depends on xbt_pkg and xbt_entity.
`default_nettype none
module xbt_lexer
    import xbt_pkg::*;
#(
    parameter int ENTITY_NAME_MAX = ENTITY_NAME_MAX_DEF,
    parameter int DTD_NEST_MAX    = DTD_NEST_MAX_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_input,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output res_list_t        results
);

    localparam int DN_W = $clog2(DTD_NEST_MAX + 1);

    typedef struct packed {
        logic [4:0]      st;
        logic [15:0]     tc;
        logic            q;
        logic [DN_W-1:0] dn;
        logic            ent_clr;
        logic            ent_inval;
        res_list_t       l;
    } step_t;

    logic            keep_ws_reg;
    logic [15:0]     limit_reg;
    logic [4:0]      st_reg;
    logic [15:0]     tc_reg;
    logic            q_reg;
    logic [DN_W-1:0] dn_reg;
    logic            inval_reg;
    logic [7:0]      ent_value;
    ent_ctl_t        ent_ctl;
    step_t           s_next;

    xbt_entity #(
        .ENTITY_NAME_MAX(ENTITY_NAME_MAX)
    ) u_entity (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (ent_ctl),
        .value(ent_value)
    );

    function automatic logic [15:0] sat_inc(logic [15:0] v);
        return (v != 16'hFFFF) ? 16'(v + 16'd1) : v;
    endfunction

    function automatic step_t text_char(step_t s, logic [7:0] c);
        step_t o;
        o = s;
        if (c == CH_AMP)
        begin
            o.ent_clr   = 1'b1;
            o.ent_inval = 1'b0;
            o.st        = S_TEXT_ENT;
        end
        else if (c != CH_NUL)
        begin
            o.l  = add_res(o.l, EV_TEXT, c);
            o.tc = sat_inc(o.tc);
        end
        return o;
    endfunction

    function automatic step_t idle_byte(step_t s, logic [7:0] c);
        step_t o;
        o    = s;
        o.st = S_IDLE;
        if (c == CH_LT) o.st = S_LT;
        else if (keep_ws_reg || !is_ws(c))
        begin
            o.tc = '0;
            o.st = S_TEXT;
            o    = text_char(o, c);
        end
        return o;
    endfunction

    function automatic step_t dtd_byte(step_t s, logic [7:0] c);
        step_t o;
        o    = s;
        o.st = S_DTD;
        if (c == CH_GT && s.dn == '0) o.st = S_IDLE;
        else if (c == CH_LBR)
        begin
            if (s.dn < DN_W'(DTD_NEST_MAX)) o.dn = s.dn + 1'b1;
        end
        else if (c == CH_RBR && s.dn != '0) o.dn = s.dn - 1'b1;
        return o;
    endfunction

    function automatic step_t tag_name_byte(step_t s, logic [7:0] c);
        step_t o;
        o    = s;
        o.st = S_TAG_NAME;
        if (c == CH_GT)
        begin
            o.l  = add_res(add_res(o.l, EV_SEP, 8'd0), EV_START_END, 8'd0);
            o.st = S_IDLE;
        end
        else if (c == CH_SLASH)
        begin
            o.l  = add_res(o.l, EV_SEP, 8'd0);
            o.st = S_SLASH;
        end
        else if (is_ws(c))
        begin
            o.l  = add_res(o.l, EV_SEP, 8'd0);
            o.st = S_ATTR_WS;
        end
        else if (c != CH_NUL) o.l = add_res(o.l, EV_TAG_NAME, c);
        return o;
    endfunction

    function automatic step_t attr_name_byte(step_t s, logic [7:0] c);
        step_t o;
        o    = s;
        o.st = S_ATTR_NAME;
        if (c == CH_GT)
        begin
            o.l  = add_res(add_res(add_res(o.l, EV_SEP, 8'd0), EV_SEP, 8'd0),
                           EV_START_END, 8'd0);
            o.st = S_IDLE;
        end
        else if (c == CH_SLASH)
        begin
            o.l  = add_res(add_res(o.l, EV_SEP, 8'd0), EV_SEP, 8'd0);
            o.st = S_SLASH;
        end
        else if (c == CH_EQ)
        begin
            o.l  = add_res(o.l, EV_SEP, 8'd0);
            o.st = S_EQ;
        end
        else if (!is_ws(c) && c != CH_NUL) o.l = add_res(o.l, EV_ATTR_NAME, c);
        return o;
    endfunction

    function automatic step_t attr_ws_byte(step_t s, logic [7:0] c);
        step_t o;
        o    = s;
        o.st = S_ATTR_WS;
        if (!is_ws(c))
        begin
            if (c == CH_GT)
            begin
                o.l  = add_res(o.l, EV_START_END, 8'd0);
                o.st = S_IDLE;
            end
            else if (c == CH_SLASH) o.st = S_SLASH;
            else o = attr_name_byte(o, c);
        end
        return o;
    endfunction

    // Close an entity with the character it decodes to, if any
    function automatic step_t ent_finish(step_t s);
        step_t o;
        o = s;
        if (inval_reg)
        begin
            if (ent_value != 8'd0) o.l = add_res(o.l, EV_ATTR_VAL, ent_value);
            o.st = S_VALUE;
        end
        else
        begin
            if (ent_value != 8'd0)
            begin
                o.l  = add_res(o.l, EV_TEXT, ent_value);
                o.tc = sat_inc(o.tc);
            end
            o.st = S_TEXT;
        end
        return o;
    endfunction

    // Next state and results for the byte or end mark on the input
    always_comb
    begin
        step_t      s;
        logic [7:0] c;
        logic       push;
        c           = in_byte;
        push        = 1'b0;
        s.st        = st_reg;
        s.tc        = tc_reg;
        s.q         = q_reg;
        s.dn        = dn_reg;
        s.ent_clr   = 1'b0;
        s.ent_inval = inval_reg;
        s.l         = '0;
        if (st_reg == S_DONE)
        begin
            s.l = add_res(s.l, EV_EOF, 8'd0);
        end
        else if (end_of_input)
        begin
            case (st_reg)
                S_TEXT:
                    s.l = add_res(s.l, EV_TEXT_END, 8'd0);
                S_TEXT_ENT:
                begin
                    s   = ent_finish(s);
                    s.l = add_res(s.l, EV_TEXT_END, 8'd0);
                end
                S_LT, S_TAG_NAME, S_EQ, S_VALUE:
                    s.l = add_res(add_res(s.l, EV_SEP, 8'd0), EV_START_END, 8'd0);
                S_ATTR_WS:
                    s.l = add_res(s.l, EV_START_END, 8'd0);
                S_ATTR_NAME:
                    s.l = add_res(add_res(add_res(s.l, EV_SEP, 8'd0), EV_SEP, 8'd0),
                                  EV_START_END, 8'd0);
                S_VALUE_ENT:
                begin
                    s   = ent_finish(s);
                    s.l = add_res(add_res(s.l, EV_SEP, 8'd0), EV_START_END, 8'd0);
                end
                S_ETAG_NAME, S_ETAG_SKIP:
                    s.l = add_res(s.l, EV_ETAG_END, 8'd0);
                S_SLASH:
                    s.l = add_res(s.l, EV_SINGLE, 8'd0);
                default:
                    s.l = s.l;
            endcase
            s.l  = add_res(s.l, EV_EOF, 8'd0);
            s.st = S_DONE;
        end
        else
        begin
            case (st_reg)
                S_TEXT:
                begin
                    if (c == CH_LT)
                    begin
                        s.l  = add_res(s.l, EV_TEXT_END, 8'd0);
                        s.st = S_LT;
                    end
                    else if (limit_reg != 16'd0 && tc_reg >= limit_reg)
                    begin
                        s.l = add_res(s.l, EV_TEXT_END, 8'd0);
                        s   = idle_byte(s, c);
                    end
                    else s = text_char(s, c);
                end
                S_TEXT_ENT, S_VALUE_ENT:
                begin
                    if (c == CH_SEMI) s = ent_finish(s);
                    else if (c != CH_NUL) push = 1'b1;
                end
                S_LT:
                begin
                    if (c == CH_SLASH)     s.st = S_ETAG_NAME;
                    else if (c == CH_QM)   s.st = S_PI;
                    else if (c == CH_BANG) s.st = S_BANG;
                    else                   s = tag_name_byte(s, c);
                end
                S_ETAG_NAME:
                begin
                    if (c == CH_GT)
                    begin
                        s.l  = add_res(s.l, EV_ETAG_END, 8'd0);
                        s.st = S_IDLE;
                    end
                    else if (is_ws(c))    s.st = S_ETAG_SKIP;
                    else if (c != CH_NUL) s.l = add_res(s.l, EV_TAG_NAME, c);
                end
                S_ETAG_SKIP:
                begin
                    if (c == CH_GT)
                    begin
                        s.l  = add_res(s.l, EV_ETAG_END, 8'd0);
                        s.st = S_IDLE;
                    end
                end
                S_PI:
                    if (c == CH_GT) s.st = S_IDLE;
                S_BANG:
                begin
                    if (c == CH_DASH) s.st = S_BANG_DASH;
                    else
                    begin
                        s.dn = '0;
                        s    = dtd_byte(s, c);
                    end
                end
                S_BANG_DASH:
                begin
                    if (c == CH_DASH) s.st = S_COM;
                    else
                    begin
                        s.dn = '0;
                        s    = dtd_byte(s, c);
                    end
                end
                S_DTD:
                    s = dtd_byte(s, c);
                S_COM:
                    if (c == CH_DASH) s.st = S_COM_D1;
                S_COM_D1:
                    s.st = (c == CH_DASH) ? S_COM_D2 : S_COM;
                S_COM_D2:
                begin
                    if (c == CH_GT)        s.st = S_IDLE;
                    else if (c != CH_DASH) s.st = S_COM;
                end
                S_TAG_NAME:
                    s = tag_name_byte(s, c);
                S_ATTR_WS:
                    s = attr_ws_byte(s, c);
                S_ATTR_NAME:
                    s = attr_name_byte(s, c);
                S_EQ:
                begin
                    if (!is_ws(c))
                    begin
                        if (c == CH_DQ || c == CH_SQ)
                        begin
                            s.q  = (c == CH_SQ);
                            s.st = S_VALUE;
                        end
                        else
                        begin
                            s.l = add_res(s.l, EV_SEP, 8'd0);
                            s   = attr_ws_byte(s, c);
                        end
                    end
                end
                S_VALUE:
                begin
                    if (c == (q_reg ? CH_SQ : CH_DQ))
                    begin
                        s.l  = add_res(s.l, EV_SEP, 8'd0);
                        s.st = S_ATTR_WS;
                    end
                    else if (c == CH_GT)
                    begin
                        s.l  = add_res(add_res(s.l, EV_SEP, 8'd0), EV_START_END, 8'd0);
                        s.st = S_IDLE;
                    end
                    else if (c == CH_AMP)
                    begin
                        s.ent_clr   = 1'b1;
                        s.ent_inval = 1'b1;
                        s.st        = S_VALUE_ENT;
                    end
                    else if (c != CH_NUL) s.l = add_res(s.l, EV_ATTR_VAL, c);
                end
                S_SLASH:
                begin
                    if (c == CH_GT)
                    begin
                        s.l  = add_res(s.l, EV_SINGLE, 8'd0);
                        s.st = S_IDLE;
                    end
                end
                default:
                    s = idle_byte(s, c);
            endcase
        end
        s_next       = s;
        ent_ctl.clr  = accept && s.ent_clr;
        ent_ctl.push = accept && push;
        ent_ctl.data = c;
    end

    assign results = s_next.l;

    // Lexer state advances on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            tc_reg    <= '0;
            q_reg     <= 1'b0;
            dn_reg    <= '0;
            inval_reg <= 1'b0;
        end
        else if (accept)
        begin
            st_reg    <= s_next.st;
            tc_reg    <= s_next.tc;
            q_reg     <= s_next.q;
            dn_reg    <= s_next.dn;
            inval_reg <= s_next.ent_inval;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_ws_reg <= 1'b0;
            limit_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEEP_WS:     keep_ws_reg <= cfg_data[0];
                REG_SPLIT_LIMIT: limit_reg   <= cfg_data;
                default:         limit_reg   <= limit_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/xbt_result_buf.sv =====
// Result buffer: holds the up to three results of one input word and hands them out in order.
// Depends on xbt_pkg.
`default_nettype none
module xbt_result_buf
    import xbt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  load,
    input  res_list_t  load_list,
    output logic       space,
    output logic       valid,
    input  wire logic  take,
    output res_t       head,
    output logic       last
);

    res_t [2:0] ent_reg;
    logic [1:0] cnt_reg;
    logic [1:0] head_reg;

    // Room for a new word when the buffer is empty or empties in this cycle
    assign space = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && take);
    assign valid = (cnt_reg != 2'd0);
    assign head  = ent_reg[head_reg];
    assign last  = (cnt_reg == 2'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            head_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg  <= load_list.n;
            head_reg <= '0;
        end
        else if (take && valid)
        begin
            cnt_reg  <= cnt_reg - 2'd1;
            head_reg <= head_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) ent_reg <= load_list.r;
    end

endmodule
`default_nettype wire
